// ----- design/wpc_pkg.sv -----
// ----------------------------------------------------------------------------
// wpc_pkg: shared types and constants
// Item, result and register-bank types, limits, state, command and register codes, option bits.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [15:0] MaxManualSec = 16'd1800;
  localparam logic [31:0] MsPerSec = 32'd1000;
  localparam logic [31:0] MsPerMin = 32'd60000;

  localparam logic [3:0] StIdle    = 4'd1;
  localparam logic [3:0] StBelow   = 4'd3;
  localparam logic [3:0] StIrrig   = 4'd4;
  localparam logic [3:0] StCool    = 4'd5;
  localparam logic [3:0] StSensErr = 4'd7;
  localparam logic [3:0] StTank    = 4'd8;
  localparam logic [3:0] StLeak    = 4'd9;
  localparam logic [3:0] StCfgErr  = 4'd10;
  localparam logic [3:0] StManual  = 4'd11;
  localparam logic [3:0] StEstop   = 4'd12;

  localparam logic [2:0] ModeUpdate    = 3'd0;
  localparam logic [2:0] ModeManualOn  = 3'd1;
  localparam logic [2:0] ModeManualOff = 3'd2;
  localparam logic [2:0] ModeEstopSet  = 3'd3;
  localparam logic [2:0] ModeEstopClr  = 3'd4;
  localparam logic [2:0] ModeClearErr  = 3'd5;

  localparam logic [CfgIdxW-1:0] RegTrigger     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStop        = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxRuntime  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStable      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinGap      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWindowStart = 3'd5;
  localparam logic [CfgIdxW-1:0] RegWindowEnd   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegOptions     = 3'd7;

  localparam int unsigned OptLinkStop   = 0;
  localparam int unsigned OptWindowEn   = 1;
  localparam int unsigned OptAllowNoClk = 2;
  localparam int unsigned OptTankEn     = 3;
  localparam int unsigned OptTankLow    = 4;
  localparam int unsigned OptLeakEn     = 5;
  localparam int unsigned OptLeakLow    = 6;

  typedef struct packed {
    logic [2:0]         mode;
    logic [31:0]        now_ms;
    logic signed [23:0] weight_g;
    logic               sensor_valid;
    logic               sensor_stable;
    logic               link_up;
    logic               tank_level;
    logic               leak_level;
    logic               clock_valid;
    logic [10:0]        minute_of_day;
    logic [15:0]        manual_run_sec;
  } wpc_item_t;

  typedef struct packed {
    logic [3:0] state_code;
    logic       pump_on;
    logic       manual_active;
    logic       estop_active;
  } wpc_result_t;

  typedef struct packed {
    logic signed [23:0] trigger_weight_g;
    logic signed [23:0] stop_weight_g;
    logic [15:0]        max_runtime_sec;
    logic [15:0]        stable_duration_sec;
    logic [10:0]        min_gap_min;
    logic [10:0]        window_start_min;
    logic [10:0]        window_end_min;
    logic [6:0]         option_flags;
  } wpc_cfg_t;

endpackage

// ----- design/wpc_if.sv -----
// ----------------------------------------------------------------------------
// wpc_if: channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface wpc_item_if;
  import wpc_pkg::*;
  logic      valid;
  logic      ready;
  wpc_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wpc_result_if;
  import wpc_pkg::*;
  logic        valid;
  logic        ready;
  wpc_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wpc_cfg_if;
  import wpc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/wpc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// wpc_cfg_regs: configuration register bank
// Takes one register write per beat; always ready.
// ----------------------------------------------------------------------------
module wpc_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  wpc_cfg_if.sink           cfg_i,
  output wpc_pkg::wpc_cfg_t cfg_o
);
  import wpc_pkg::*;

  wpc_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        RegTrigger:     cfg_d.trigger_weight_g = cfg_i.data[23:0];
        RegStop:        cfg_d.stop_weight_g = cfg_i.data[23:0];
        RegMaxRuntime:  cfg_d.max_runtime_sec = cfg_i.data[15:0];
        RegStable:      cfg_d.stable_duration_sec = cfg_i.data[15:0];
        RegMinGap:      cfg_d.min_gap_min = cfg_i.data[10:0];
        RegWindowStart: cfg_d.window_start_min = cfg_i.data[10:0];
        RegWindowEnd:   cfg_d.window_end_min = cfg_i.data[10:0];
        RegOptions:     cfg_d.option_flags = cfg_i.data[6:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{trigger_weight_g: 24'sd0, stop_weight_g: 24'sd0,
                 max_runtime_sec: 16'd600, stable_duration_sec: 16'd10,
                 min_gap_min: 11'd0, window_start_min: 11'd0,
                 window_end_min: 11'd0, option_flags: 7'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/wpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpc_ctrl: controller state and step logic
// Applies one command to the controller state per enabled cycle.
// ----------------------------------------------------------------------------
module wpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  wpc_pkg::wpc_item_t   item_i,
  input  wpc_pkg::wpc_cfg_t    cfg_i,
  output wpc_pkg::wpc_result_t result_o
);
  import wpc_pkg::*;

  logic [3:0]  state_q, state_d;
  logic        pump_q, pump_d;
  logic        manual_q, manual_d;
  logic        estop_q, estop_d;
  logic [31:0] start_ms_q, start_ms_d;
  logic [31:0] below_ms_q, below_ms_d;
  logic [31:0] last_ms_q, last_ms_d;
  logic [31:0] mstop_ms_q, mstop_ms_d;

  logic        tank_trip, leak_trip;
  logic        cool_done, window_ok, can_start;
  logic        weight_at_stop, run_expired, stable_done, mdeadline_hit;
  logic [15:0] cap_sec;
  logic [31:0] since_last, since_start, since_below;
  logic [6:0]  opt;
  logic [10:0] minute;

  assign opt    = cfg_i.option_flags;
  assign minute = item_i.minute_of_day;

  assign tank_trip = opt[OptTankEn] & (opt[OptTankLow] ? ~item_i.tank_level : item_i.tank_level);
  assign leak_trip = opt[OptLeakEn] & (opt[OptLeakLow] ? ~item_i.leak_level : item_i.leak_level);

  assign since_last  = item_i.now_ms - last_ms_q;
  assign since_start = item_i.now_ms - start_ms_q;
  assign since_below = item_i.now_ms - below_ms_q;

  assign cool_done = (last_ms_q == '0) ||
                     (since_last >= 32'(cfg_i.min_gap_min) * MsPerMin);
  assign run_expired = since_start >= 32'(cfg_i.max_runtime_sec) * MsPerSec;
  assign stable_done = since_below >= 32'(cfg_i.stable_duration_sec) * MsPerSec;
  assign weight_at_stop = item_i.weight_g >= cfg_i.stop_weight_g;
  assign mdeadline_hit = (mstop_ms_q != '0) && (item_i.now_ms >= mstop_ms_q);

  always_comb begin
    if (!opt[OptWindowEn]) begin
      window_ok = 1'b1;
    end else if (!item_i.clock_valid) begin
      window_ok = opt[OptAllowNoClk];
    end else if (cfg_i.window_start_min == cfg_i.window_end_min) begin
      window_ok = 1'b1;
    end else if (cfg_i.window_start_min < cfg_i.window_end_min) begin
      window_ok = (minute >= cfg_i.window_start_min) && (minute <= cfg_i.window_end_min);
    end else begin
      window_ok = (minute >= cfg_i.window_start_min) || (minute <= cfg_i.window_end_min);
    end
  end

  assign can_start = item_i.sensor_valid && item_i.sensor_stable && !pump_q &&
                     cool_done && window_ok && (item_i.weight_g <= cfg_i.trigger_weight_g);

  assign cap_sec = ((item_i.manual_run_sec == '0) || (item_i.manual_run_sec > MaxManualSec)) ?
                   MaxManualSec : item_i.manual_run_sec;

  always_comb begin
    state_d    = state_q;
    pump_d     = pump_q;
    manual_d   = manual_q;
    estop_d    = estop_q;
    start_ms_d = start_ms_q;
    below_ms_d = below_ms_q;
    last_ms_d  = last_ms_q;
    mstop_ms_d = mstop_ms_q;
    case (item_i.mode)
      ModeUpdate: begin
        if (estop_q) begin
          pump_d  = 1'b0;
          state_d = StEstop;
        end else if (tank_trip) begin
          pump_d  = 1'b0;
          state_d = StTank;
        end else if (leak_trip) begin
          pump_d  = 1'b0;
          state_d = StLeak;
        end else begin
          if (state_q == StTank || state_q == StLeak) begin
            state_d = StIdle;
          end
          if (opt[OptLinkStop] && !item_i.link_up && pump_q) begin
            pump_d    = 1'b0;
            last_ms_d = item_i.now_ms;
            state_d   = StCool;
          end else if (!item_i.sensor_valid) begin
            pump_d  = 1'b0;
            state_d = StSensErr;
          end else if (manual_q) begin
            if (mdeadline_hit) begin
              pump_d     = 1'b0;
              manual_d   = 1'b0;
              mstop_ms_d = '0;
              last_ms_d  = item_i.now_ms;
              state_d    = StCool;
            end
          end else if (pump_q && (weight_at_stop || run_expired)) begin
            pump_d    = 1'b0;
            last_ms_d = item_i.now_ms;
            state_d   = StCool;
          end else begin
            case (state_d)
              StIdle, StCool: begin
                if (state_d == StIdle || cool_done) begin
                  state_d = StIdle;
                  if (can_start) begin
                    below_ms_d = item_i.now_ms;
                    state_d    = StBelow;
                  end
                end
              end
              StBelow: begin
                if (!can_start) begin
                  state_d = StIdle;
                end else if (stable_done) begin
                  pump_d     = 1'b1;
                  start_ms_d = item_i.now_ms;
                  state_d    = StIrrig;
                end
              end
              StSensErr: begin
                if (item_i.sensor_valid && item_i.sensor_stable) begin
                  state_d = StIdle;
                end
              end
              default: state_d = state_d;
            endcase
          end
        end
      end
      ModeManualOn: begin
        if (estop_q) begin
          state_d = state_q;
        end else if (tank_trip) begin
          pump_d  = 1'b0;
          state_d = StTank;
        end else if (leak_trip) begin
          pump_d  = 1'b0;
          state_d = StLeak;
        end else begin
          manual_d   = 1'b1;
          state_d    = StManual;
          mstop_ms_d = item_i.now_ms + 32'(cap_sec) * MsPerSec;
          pump_d     = 1'b1;
          start_ms_d = item_i.now_ms;
        end
      end
      ModeManualOff: begin
        pump_d     = 1'b0;
        manual_d   = 1'b0;
        mstop_ms_d = '0;
        last_ms_d  = item_i.now_ms;
        state_d    = StCool;
      end
      ModeEstopSet: begin
        estop_d  = 1'b1;
        pump_d   = 1'b0;
        manual_d = 1'b0;
        state_d  = StEstop;
      end
      ModeEstopClr: begin
        estop_d = 1'b0;
        state_d = StIdle;
      end
      ModeClearErr: begin
        if (state_q inside {StSensErr, StTank, StLeak, StCfgErr}) begin
          state_d = StIdle;
        end
      end
      default: state_d = state_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      pump_q     <= 1'b0;
      manual_q   <= 1'b0;
      estop_q    <= 1'b0;
      start_ms_q <= '0;
      below_ms_q <= '0;
      last_ms_q  <= '0;
      mstop_ms_q <= '0;
    end else if (en_i) begin
      state_q    <= state_d;
      pump_q     <= pump_d;
      manual_q   <= manual_d;
      estop_q    <= estop_d;
      start_ms_q <= start_ms_d;
      below_ms_q <= below_ms_d;
      last_ms_q  <= last_ms_d;
      mstop_ms_q <= mstop_ms_d;
    end
  end

  assign result_o = '{state_code: state_q, pump_on: pump_q,
                      manual_active: manual_q, estop_active: estop_q};

  a_estop_pump_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    estop_q |-> !pump_q && !manual_q)
    else $error("pump or manual run active while estop latched");

  a_estop_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.mode == ModeEstopSet |=> estop_q && state_q == StEstop)
    else $error("estop set command did not latch estop");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(state_q) && $stable(pump_q) && $stable(last_ms_q))
    else $error("controller state moved without a beat");

endmodule

// ----- design/weight_triggered_pump_controller_core.sv -----
// ----------------------------------------------------------------------------
// weight_triggered_pump_controller_core: weight-triggered pump controller
// Input stage, controller state and result handshake.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries one command beat (mode plus a snapshot of time, weight,
//   sensor, link, tank, leak and clock inputs). result_o returns one beat per
//   item with the state code, pump drive, manual and estop flags after the
//   command. cfg_i writes one configuration register per beat and is always
//   ready; write it only while no item is in flight.
//   An accepted item is held in the input register, then applied by the
//   controller state update, whose registers also drive the result; result
//   valid rises with that update, and an output stall keeps the item waiting
//   in the input register. Throughput is one item per cycle while the receiver
//   is ready, set by the step logic on the controller state.
//   When the receiver stalls, the result and controller state hold; one more
//   item is taken into the input register, then item_i.ready drops.
//   Reset clears both pipeline stages, loads the register defaults and puts
//   the controller in idle with the pump off.
// ----------------------------------------------------------------------------
module weight_triggered_pump_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpc_cfg_if.sink     cfg_i,
  wpc_item_if.sink    item_i,
  wpc_result_if.source result_o
);
  import wpc_pkg::*;

  wpc_cfg_t  cfg;
  wpc_item_t item_q;
  logic      in_valid_q;
  logic      out_valid_q;
  logic      out_free;
  logic      advance;

  assign out_free     = !out_valid_q || result_o.ready;
  assign advance      = in_valid_q && out_free;
  assign item_i.ready = !in_valid_q || out_free;
  assign result_o.valid = out_valid_q;

  wpc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  wpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_o.data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.valid && item_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q <= item_i.data;
    end
  end

  a_out_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result beat without a staged item");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(item_q))
    else $error("staged item lost during output stall");

endmodule

// ----- verif/wpc_status_checker.sv -----
// ----------------------------------------------------------------------------
// wpc_status_checker: status predictor and scoreboard for the pump controller
// Tracks register writes, predicts the status beat for every accepted command
// beat from its own copy of the controller state, and compares each accepted
// result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module wpc_status_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [wpc_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [wpc_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                 item_valid_i,
  input  logic                                 item_ready_i,
  input  wpc_pkg::wpc_item_t                   item_data_i,
  input  logic                                 res_valid_i,
  input  logic                                 res_ready_i,
  input  wpc_pkg::wpc_result_t                 res_data_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o
);
  import wpc_pkg::*;

  localparam logic [3:0] StCalib = 4'd6;

  wpc_cfg_t    cfg_q;
  logic [3:0]  ctl_state;
  logic        pump_run;
  logic [31:0] run_start_ms;
  logic [31:0] below_since_ms;
  logic [31:0] last_end_ms;
  logic [31:0] man_deadline_ms;
  logic        man_active;
  logic        estop_latched;

  wpc_result_t expected_status_q[$];
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  function automatic bit interlock_clear(wpc_item_t it);
    logic tank_hit;
    logic leak_hit;
    tank_hit = 1'b0;
    leak_hit = 1'b0;
    if (cfg_q.option_flags[OptTankEn]) begin
      tank_hit = cfg_q.option_flags[OptTankLow] ? !it.tank_level : it.tank_level;
    end
    if (cfg_q.option_flags[OptLeakEn]) begin
      leak_hit = cfg_q.option_flags[OptLeakLow] ? !it.leak_level : it.leak_level;
    end
    if (tank_hit) begin
      pump_run = 1'b0;
      ctl_state = StTank;
      return 1'b0;
    end
    if (leak_hit) begin
      pump_run = 1'b0;
      ctl_state = StLeak;
      return 1'b0;
    end
    if (ctl_state == StTank || ctl_state == StLeak) ctl_state = StIdle;
    return 1'b1;
  endfunction

  function automatic bit gap_elapsed(logic [31:0] now);
    logic [31:0] since_end;
    logic [31:0] gap_ms;
    if (last_end_ms == 32'd0) return 1'b1;
    since_end = now - last_end_ms;
    gap_ms = 32'(cfg_q.min_gap_min) * MsPerMin;
    return since_end >= gap_ms;
  endfunction

  function automatic bit window_open(wpc_item_t it);
    logic [10:0] ws;
    logic [10:0] we;
    ws = cfg_q.window_start_min;
    we = cfg_q.window_end_min;
    if (!cfg_q.option_flags[OptWindowEn]) return 1'b1;
    if (!it.clock_valid) return cfg_q.option_flags[OptAllowNoClk];
    if (ws == we) return 1'b1;
    if (ws < we) return it.minute_of_day >= ws && it.minute_of_day <= we;
    return it.minute_of_day >= ws || it.minute_of_day <= we;
  endfunction

  function automatic bit start_allowed(wpc_item_t it);
    if (!it.sensor_valid || !it.sensor_stable) return 1'b0;
    if (pump_run) return 1'b0;
    if (!gap_elapsed(it.now_ms)) return 1'b0;
    if (!window_open(it)) return 1'b0;
    if (ctl_state == StSensErr || ctl_state == StCfgErr ||
        ctl_state == StEstop || ctl_state == StCalib) return 1'b0;
    return $signed(it.weight_g) <= $signed(cfg_q.trigger_weight_g);
  endfunction

  function automatic void end_run(logic [31:0] now);
    pump_run = 1'b0;
    last_end_ms = now;
    ctl_state = StCool;
  endfunction

  function automatic void end_manual(logic [31:0] now);
    pump_run = 1'b0;
    man_active = 1'b0;
    man_deadline_ms = 32'd0;
    last_end_ms = now;
    ctl_state = StCool;
  endfunction

  function automatic void periodic_update(wpc_item_t it);
    logic [31:0] run_sec;
    logic [31:0] below_ms;
    if (estop_latched) begin
      pump_run = 1'b0;
      ctl_state = StEstop;
      return;
    end
    if (!interlock_clear(it)) return;
    if (cfg_q.option_flags[OptLinkStop] && !it.link_up && pump_run) begin
      end_run(it.now_ms);
      return;
    end
    if (!it.sensor_valid) begin
      pump_run = 1'b0;
      ctl_state = StSensErr;
      return;
    end
    if (man_active) begin
      if (man_deadline_ms != 32'd0 && it.now_ms >= man_deadline_ms) end_manual(it.now_ms);
      return;
    end
    if (pump_run) begin
      run_sec = (it.now_ms - run_start_ms) / MsPerSec;
      if ($signed(it.weight_g) >= $signed(cfg_q.stop_weight_g)) begin
        end_run(it.now_ms);
        return;
      end
      if (run_sec >= 32'(cfg_q.max_runtime_sec)) begin
        end_run(it.now_ms);
        return;
      end
    end
    case (ctl_state)
      StIdle, StCool: begin
        if (ctl_state == StCool) begin
          if (!gap_elapsed(it.now_ms)) return;
          ctl_state = StIdle;
        end
        if (start_allowed(it)) begin
          below_since_ms = it.now_ms;
          ctl_state = StBelow;
        end
      end
      StBelow: begin
        below_ms = it.now_ms - below_since_ms;
        if (!start_allowed(it)) begin
          ctl_state = StIdle;
        end else if (below_ms >= 32'(cfg_q.stable_duration_sec) * MsPerSec) begin
          pump_run = 1'b1;
          run_start_ms = it.now_ms;
          ctl_state = StIrrig;
        end
      end
      StSensErr: begin
        if (it.sensor_valid && it.sensor_stable) ctl_state = StIdle;
      end
      default: ;
    endcase
  endfunction

  function automatic void manual_start(wpc_item_t it);
    logic [31:0] cap_sec;
    if (estop_latched) return;
    if (!interlock_clear(it)) return;
    man_active = 1'b1;
    ctl_state = StManual;
    if (it.manual_run_sec == 16'd0 || it.manual_run_sec > MaxManualSec) begin
      cap_sec = 32'(MaxManualSec);
    end else begin
      cap_sec = 32'(it.manual_run_sec);
    end
    man_deadline_ms = it.now_ms + cap_sec * MsPerSec;
    pump_run = 1'b1;
    run_start_ms = it.now_ms;
  endfunction

  function automatic wpc_result_t irrigation_step(wpc_item_t it);
    wpc_result_t r;
    case (it.mode)
      ModeUpdate:    periodic_update(it);
      ModeManualOn:  manual_start(it);
      ModeManualOff: end_manual(it.now_ms);
      ModeEstopSet: begin
        estop_latched = 1'b1;
        pump_run = 1'b0;
        man_active = 1'b0;
        ctl_state = StEstop;
      end
      ModeEstopClr: begin
        estop_latched = 1'b0;
        ctl_state = StIdle;
      end
      ModeClearErr: begin
        if (ctl_state == StSensErr || ctl_state == StTank ||
            ctl_state == StLeak || ctl_state == StCfgErr) ctl_state = StIdle;
      end
      default: ;
    endcase
    r.state_code    = ctl_state;
    r.pump_on       = pump_run;
    r.manual_active = man_active;
    r.estop_active  = estop_latched;
    return r;
  endfunction

  function automatic void apply_register_write(logic [CfgIdxW-1:0] idx,
                                               logic [CfgDataW-1:0] value);
    case (idx)
      RegTrigger:     cfg_q.trigger_weight_g    = value[23:0];
      RegStop:        cfg_q.stop_weight_g       = value[23:0];
      RegMaxRuntime:  cfg_q.max_runtime_sec     = value[15:0];
      RegStable:      cfg_q.stable_duration_sec = value[15:0];
      RegMinGap:      cfg_q.min_gap_min         = value[10:0];
      RegWindowStart: cfg_q.window_start_min    = value[10:0];
      RegWindowEnd:   cfg_q.window_end_min      = value[10:0];
      RegOptions:     cfg_q.option_flags        = value[6:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wpc_result_t want;
    if (!rst_ni) begin
      cfg_q.trigger_weight_g    = '0;
      cfg_q.stop_weight_g       = '0;
      cfg_q.max_runtime_sec     = 16'd600;
      cfg_q.stable_duration_sec = 16'd10;
      cfg_q.min_gap_min         = '0;
      cfg_q.window_start_min    = '0;
      cfg_q.window_end_min      = '0;
      cfg_q.option_flags        = '0;
      ctl_state       = StIdle;
      pump_run        = 1'b0;
      run_start_ms    = '0;
      below_since_ms  = '0;
      last_end_ms     = '0;
      man_deadline_ms = '0;
      man_active      = 1'b0;
      estop_latched   = 1'b0;
      expected_status_q.delete();
      outstanding = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_register_write(cfg_index_i, cfg_data_i);
      if (item_valid_i && item_ready_i) expected_status_q.push_back(irrigation_step(item_data_i));
      if (res_valid_i && res_ready_i) begin
        if (expected_status_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no prediction, expected none, actual state %0d",
                   $time, res_data_i.state_code);
        end else begin
          want = expected_status_q.pop_front();
          check_field("state_code", want.state_code, res_data_i.state_code);
          check_field("pump_on", want.pump_on, res_data_i.pump_on);
          check_field("manual_active", want.manual_active, res_data_i.manual_active);
          check_field("estop_active", want.estop_active, res_data_i.estop_active);
        end
      end
      outstanding = expected_status_q.size();
    end
  end

endmodule

// ----- verif/weight_triggered_pump_controller_core_tb.sv -----
// ----------------------------------------------------------------------------
// weight_triggered_pump_controller_core_tb: testbench for the pump controller
// Runs a directed command sequence on reset defaults, then random phases of
// command beats under several register settings, extremes included, with
// bursty sending and a stalling receiver. The status checker scores results.
// ----------------------------------------------------------------------------
module weight_triggered_pump_controller_core_tb;
  import wpc_pkg::*;

  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned PhaseCount = 7;

  logic clk_i = 1'b0;
  logic rst_ni;

  wpc_cfg_if    cfg_bus ();
  wpc_item_if   item_bus ();
  wpc_result_if result_bus ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned burst_left = 0;

  logic [31:0] clock_ms = 32'd0;
  int          trig_g = 0;
  int          stop_g = 0;
  logic [6:0]  opt_shadow = 7'd0;

  weight_triggered_pump_controller_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  wpc_status_checker status_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_bus.valid),
    .cfg_ready_i  (cfg_bus.ready),
    .cfg_index_i  (cfg_bus.index),
    .cfg_data_i   (cfg_bus.data),
    .item_valid_i (item_bus.valid),
    .item_ready_i (item_bus.ready),
    .item_data_i  (item_bus.data),
    .res_valid_i  (result_bus.valid),
    .res_ready_i  (result_bus.ready),
    .res_data_i   (result_bus.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[weight_triggered_pump_controller_core] ERROR");
      $finish;
    end
  end

  // receiver: random ready pattern, long hold-off on request
  initial begin
    int unsigned pattern_left;
    int unsigned ready_pct;
    pattern_left = 0;
    ready_pct = 100;
    result_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        result_bus.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(8, 60);
          case ($urandom_range(0, 4))
            0, 1:    ready_pct = 100;
            2:       ready_pct = 75;
            3:       ready_pct = 40;
            default: ready_pct = 10;
          endcase
        end
        pattern_left--;
        result_bus.ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  task automatic send_item(input wpc_item_t it);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.data  <= it;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_settings(input int unsigned phase);
    logic [15:0] max_rt;
    logic [15:0] stable_s;
    logic [10:0] gap_min;
    logic [10:0] ws;
    logic [10:0] we;
    case (phase)
      1: begin
        trig_g = 500; stop_g = 900; max_rt = 16'd8; stable_s = 16'd2;
        gap_min = 11'd0; ws = 11'd0; we = 11'd0; opt_shadow = 7'd0;
      end
      2: begin
        trig_g = -8388608; stop_g = 8388607; max_rt = 16'hFFFF; stable_s = 16'hFFFF;
        gap_min = 11'd2047; ws = 11'd1439; we = 11'd0; opt_shadow = 7'h7F;
      end
      3: begin
        trig_g = 8388607; stop_g = -8388608; max_rt = 16'd0; stable_s = 16'd0;
        gap_min = 11'd0; ws = 11'd0; we = 11'd1439; opt_shadow = 7'h0B;
      end
      default: begin
        trig_g = int'($urandom_range(0, 2000)) - 1000;
        stop_g = trig_g + int'($urandom_range(0, 1500));
        max_rt = 16'($urandom_range(1, 40));
        stable_s = 16'($urandom_range(0, 6));
        gap_min = 11'($urandom_range(0, 2));
        ws = 11'($urandom_range(0, 1439));
        we = 11'($urandom_range(0, 1439));
        opt_shadow = 7'($urandom_range(0, 127));
      end
    endcase
    write_reg(RegTrigger, 24'(trig_g));
    write_reg(RegStop, 24'(stop_g));
    write_reg(RegMaxRuntime, 24'(max_rt));
    write_reg(RegStable, 24'(stable_s));
    write_reg(RegMinGap, 24'(gap_min));
    write_reg(RegWindowStart, 24'(ws));
    write_reg(RegWindowEnd, 24'(we));
    write_reg(RegOptions, 24'(opt_shadow));
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic wpc_item_t cmd(logic [2:0] mode, logic [31:0] now,
                                    logic signed [23:0] w, logic [15:0] run_sec = 16'd0);
    wpc_item_t it;
    it.mode           = mode;
    it.now_ms         = now;
    it.weight_g       = w;
    it.sensor_valid   = 1'b1;
    it.sensor_stable  = 1'b1;
    it.link_up        = 1'b1;
    it.tank_level     = 1'b0;
    it.leak_level     = 1'b0;
    it.clock_valid    = 1'b1;
    it.minute_of_day  = 11'd0;
    it.manual_run_sec = run_sec;
    return it;
  endfunction

  function automatic wpc_item_t random_command();
    wpc_item_t it;
    int unsigned r;
    int w;
    r = $urandom_range(0, 99);
    if (r < 78)      it.mode = ModeUpdate;
    else if (r < 84) it.mode = ModeManualOn;
    else if (r < 88) it.mode = ModeManualOff;
    else if (r < 90) it.mode = ModeEstopSet;
    else if (r < 94) it.mode = ModeEstopClr;
    else if (r < 98) it.mode = ModeClearErr;
    else             it.mode = $urandom_range(0, 1) ? ModeSpare6 : ModeSpare7;

    r = $urandom_range(0, 99);
    if (r < 60)      clock_ms = clock_ms + $urandom_range(0, 1500);
    else if (r < 85) clock_ms = clock_ms + $urandom_range(1500, 15000);
    else if (r < 93) clock_ms = clock_ms + $urandom_range(15000, 120000);
    else if (r >= 97) clock_ms = $urandom();
    it.now_ms = clock_ms;

    r = $urandom_range(0, 99);
    if (r < 35)      w = trig_g - int'($urandom_range(0, 300));
    else if (r < 60) w = trig_g + int'($urandom_range(0, 300));
    else if (r < 85) w = stop_g + int'($urandom_range(0, 300)) - 100;
    else             w = int'($urandom());
    it.weight_g = 24'(w);

    it.sensor_valid  = ($urandom_range(0, 99) < 95);
    it.sensor_stable = ($urandom_range(0, 99) < 90);
    it.link_up       = ($urandom_range(0, 99) < 92);
    it.clock_valid   = ($urandom_range(0, 99) < 85);
    // hold the interlock pins mostly at their quiet level
    it.tank_level = ($urandom_range(0, 99) < 90) ? opt_shadow[OptTankLow] : 1'($urandom());
    it.leak_level = ($urandom_range(0, 99) < 93) ? opt_shadow[OptLeakLow] : 1'($urandom());
    it.minute_of_day = ($urandom_range(0, 9) != 0) ? 11'($urandom_range(0, 1439))
                                                     : 11'($urandom_range(0, 2047));
    r = $urandom_range(0, 9);
    if (r < 5)      it.manual_run_sec = 16'($urandom_range(0, 30));
    else if (r < 8) it.manual_run_sec = 16'($urandom_range(0, 2000));
    else            it.manual_run_sec = 16'($urandom());
    return it;
  endfunction

  initial begin
    wpc_item_t it;
    rst_ni         <= 1'b0;
    item_bus.valid <= 1'b0;
    item_bus.data  <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= '0;
    cfg_bus.data   <= '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(cmd(ModeUpdate, 32'd0, 24'sh7FFFFF));
    send_item(cmd(ModeUpdate, 32'd100, 24'sh800000));
    send_item(cmd(ModeUpdate, 32'd10100, -24'sd100));
    send_item(cmd(ModeUpdate, 32'd11000, 24'sd0));
    it = cmd(ModeUpdate, 32'd12000, 24'sd50);
    it.sensor_valid = 1'b0;
    send_item(it);
    it = cmd(ModeUpdate, 32'd12500, 24'sd50);
    it.sensor_stable = 1'b0;
    send_item(it);
    send_item(cmd(ModeClearErr, 32'd13000, 24'sd50));
    send_item(cmd(ModeManualOn, 32'd14000, 24'sd50, 16'd0));
    send_item(cmd(ModeUpdate, 32'd1814000, 24'sd50));
    send_item(cmd(ModeManualOn, 32'd1815000, 24'sd50, 16'hFFFF));
    send_item(cmd(ModeManualOff, 32'd1816000, 24'sd50));
    send_item(cmd(ModeManualOff, 32'd1817000, 24'sd50));
    send_item(cmd(ModeEstopSet, 32'd1818000, 24'sd50));
    send_item(cmd(ModeManualOn, 32'd1819000, 24'sd50, 16'd5));
    send_item(cmd(ModeUpdate, 32'd1820000, 24'sd50));
    send_item(cmd(ModeEstopClr, 32'd1821000, 24'sd50));
    send_item(cmd(ModeSpare6, 32'd1822000, 24'sd50));
    send_item(cmd(ModeSpare7, 32'd1823000, 24'sd50));
    // deadline wraps to zero: manual run never times out
    send_item(cmd(ModeManualOn, 32'hFFFF_FC18, 24'sd0, 16'd1));
    it = cmd(ModeUpdate, 32'hFFFF_FFFF, 24'sd0);
    it.link_up       = 1'b0;
    it.clock_valid   = 1'b0;
    it.tank_level    = 1'b1;
    it.leak_level    = 1'b1;
    it.minute_of_day = 11'h7FF;
    send_item(it);
    send_item(cmd(ModeManualOff, 32'd0, 24'sd0));
    send_item(cmd(ModeUpdate, 32'd5, -24'sd1));

    for (int unsigned phase = 1; phase <= PhaseCount; phase++) begin
      drain_results();
      program_settings(phase);
      if (phase == 5) clock_ms = 32'hFFFE_8000;
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if ((phase == 1 || phase == 5) && n == 30) hold_requests++;
        send_item(random_command());
      end
    end

    item_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[weight_triggered_pump_controller_core] OK");
    end else begin
      $display("[weight_triggered_pump_controller_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/wpc_pkg.sv
design/wpc_if.sv
design/wpc_cfg_regs.sv
design/wpc_ctrl.sv
design/weight_triggered_pump_controller_core.sv
verif/wpc_status_checker.sv
verif/weight_triggered_pump_controller_core_tb.sv
